// File: hdl/ttc_pkg.sv
// shared types and constants of the touch tracker
package ttc_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int NW          = $clog2(MAX_RESULTS);

  localparam logic [15:0] TIMEOUT_RST  = 16'd100;
  localparam logic [31:0] SCR_ZERO_RST = 32'h0000_0000;
  localparam logic [31:0] SCR_ONE_RST  = 32'h0000_0100;
  localparam logic [31:0] SCR_TWO_RST  = 32'h0100_0000;
  localparam logic [31:0] SEN_ZERO_RST = 32'h0000_0000;
  localparam logic [31:0] SEN_ONE_RST  = 32'h0000_0001;
  localparam logic [31:0] SEN_TWO_RST  = 32'h0001_0000;

  typedef enum logic [1:0] {
    EV_ADD    = 2'd0,
    EV_MOVE   = 2'd1,
    EV_REMOVE = 2'd2,
    EV_DROP   = 2'd3
  } ev_type_t;

  typedef enum logic [2:0] {
    CFG_TIMEOUT  = 3'd0,
    CFG_SCR_ZERO = 3'd1,
    CFG_SCR_ONE  = 3'd2,
    CFG_SCR_TWO  = 3'd3,
    CFG_SEN_ZERO = 3'd4,
    CFG_SEN_ONE  = 3'd5,
    CFG_SEN_TWO  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_FIND = 2'd0,
    MODE_EXP  = 2'd1,
    MODE_MIN  = 2'd2
  } scan_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_SCAN, ST_DRAIN, ST_DECIDE, ST_START, ST_CALC, ST_OUT
  } ctrl_st_t;

  typedef enum logic [2:0] {
    CS_IDLE, CS_MUL, CS_ACC, CS_DIVI, CS_DIV
  } cal_st_t;

  typedef struct packed {
    logic       load_in;
    logic       rd_en;
    scan_mode_t mode;
    logic       scan_clr;
    logic       ev_load;
    logic       cal_start;
    logic       out_load;
    logic       last;
  } ttc_cmd_t;

  typedef struct packed {
    logic kind;
    logic id_neg;
    logic best;
    logic none_left;
    logic cal_done;
    logic out_free;
  } ttc_sts_t;

  typedef struct packed {
    logic [14:0] id;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] pr;
    logic [31:0] seen;
  } slot_t;

endpackage

// File: hdl/ttc_in_if.sv
// input channel: touch reports and sweep requests
interface ttc_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic        [31:0] now_ms;
  logic signed [15:0] finger_id;
  logic signed [15:0] touch_x;
  logic signed [15:0] touch_y;
  logic        [15:0] press_lvl;

  modport source (output valid, kind, now_ms, finger_id, touch_x, touch_y, press_lvl,
                  input ready);
  modport sink (input valid, kind, now_ms, finger_id, touch_x, touch_y, press_lvl,
                output ready);
endinterface

// File: hdl/ttc_out_if.sv
// result channel: touch events
interface ttc_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  event_type;
  logic        [14:0] event_id;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;
  logic signed [15:0] raw_x;
  logic signed [15:0] raw_y;
  logic        [15:0] pressure;
  logic               last_of_run;

  modport source (output valid, event_type, event_id, screen_x, screen_y, raw_x, raw_y,
                  pressure, last_of_run, input ready);
  modport sink (input valid, event_type, event_id, screen_x, screen_y, raw_x, raw_y,
                pressure, last_of_run, output ready);
endinterface

// File: hdl/ttc_cal.sv
// iterative three-point calibration unit: shared multiplier and restoring divider
module ttc_cal (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic        [31:0] scr_zero,
  input  logic        [31:0] scr_one,
  input  logic        [31:0] scr_two,
  input  logic        [31:0] sen_zero,
  input  logic        [31:0] sen_one,
  input  logic        [31:0] sen_two,
  output logic               done,
  output logic signed [15:0] scr_x,
  output logic signed [15:0] scr_y
);
  import ttc_pkg::*;

  cal_st_t st_r, st_nxt;

  logic signed [15:0] x_r, y_r;
  logic        [2:0]  ph_r;
  logic               j_r;
  logic signed [35:0] prod_r;
  logic signed [39:0] acc_r;
  logic signed [34:0] dot_r;
  logic        [33:0] n2_r;
  logic        [17:0] l1_r, l2_r;
  logic        [33:0] rem_r;
  logic        [17:0] nb_r;
  logic        [17:0] q_r;
  logic        [4:0]  cnt_r;
  logic signed [15:0] sx_r, sy_r;
  logic               done_r;

  logic signed [16:0] c0x, c0y, dx, dy, c1x, c1y, c2x, c2y;
  logic signed [16:0] b1x, b1y, b2x, b2y;
  logic signed [18:0] opa;
  logic signed [16:0] opb;
  logic signed [35:0] mul;
  logic signed [39:0] acc_sum;
  logic        [34:0] abs_w;
  logic        [33:0] a_mag;
  logic               big;
  logic        [34:0] rem_sh, rem_sub;
  logic               ge;
  logic        [17:0] q_fin;
  logic signed [39:0] init_x, init_y;
  logic signed [23:0] r_full;
  logic signed [15:0] r_sat;
  logic               l_wr;
  logic        [17:0] l_val;

  assign c0x = $signed({sen_zero[15], sen_zero[15:0]});
  assign c0y = $signed({sen_zero[31], sen_zero[31:16]});
  assign dx  = $signed({x_r[15], x_r}) - c0x;
  assign dy  = $signed({y_r[15], y_r}) - c0y;
  assign c1x = $signed({sen_one[15], sen_one[15:0]}) - c0x;
  assign c1y = $signed({sen_one[31], sen_one[31:16]}) - c0y;
  assign c2x = $signed({sen_two[15], sen_two[15:0]}) - c0x;
  assign c2y = $signed({sen_two[31], sen_two[31:16]}) - c0y;
  assign b1x = $signed({scr_one[15], scr_one[15:0]}) - $signed({scr_zero[15], scr_zero[15:0]});
  assign b1y = $signed({scr_one[31], scr_one[31:16]}) - $signed({scr_zero[31], scr_zero[31:16]});
  assign b2x = $signed({scr_two[15], scr_two[15:0]}) - $signed({scr_zero[15], scr_zero[15:0]});
  assign b2y = $signed({scr_two[31], scr_two[31:16]}) - $signed({scr_zero[31], scr_zero[31:16]});

  assign init_x = $signed({{8{scr_zero[15]}}, scr_zero[15:0], 16'h8000});
  assign init_y = $signed({{8{scr_zero[31]}}, scr_zero[31:16], 16'h8000});

  // operand selection per phase and term
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (ph_r)
      3'd0: begin
        opa = j_r ? {dy[16], dy[16], dy} : {dx[16], dx[16], dx};
        opb = j_r ? c1y : c1x;
      end
      3'd1: begin
        opa = j_r ? {c1y[16], c1y[16], c1y} : {c1x[16], c1x[16], c1x};
        opb = j_r ? c1y : c1x;
      end
      3'd2: begin
        opa = j_r ? {dy[16], dy[16], dy} : {dx[16], dx[16], dx};
        opb = j_r ? c2y : c2x;
      end
      3'd3: begin
        opa = j_r ? {c2y[16], c2y[16], c2y} : {c2x[16], c2x[16], c2x};
        opb = j_r ? c2y : c2x;
      end
      3'd4: begin
        opa = j_r ? $signed({1'b0, l2_r}) : $signed({1'b0, l1_r});
        opb = j_r ? b2x : b1x;
      end
      3'd5: begin
        opa = j_r ? $signed({1'b0, l2_r}) : $signed({1'b0, l1_r});
        opb = j_r ? b2y : b1y;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign mul     = opa * opb;
  assign acc_sum = acc_r + {{4{prod_r[35]}}, prod_r};

  assign abs_w = dot_r[34] ? (35'd0 - $unsigned(dot_r)) : $unsigned(dot_r);
  assign a_mag = abs_w[33:0];
  assign big   = {2'b00, a_mag} >= {n2_r, 2'b00};

  assign rem_sh  = {rem_r, nb_r[17]};
  assign ge      = rem_sh >= {1'b0, n2_r};
  assign rem_sub = rem_sh - {1'b0, n2_r};
  assign q_fin   = {q_r[16:0], ge};

  // round half up to q16.0 (signed 16-bit integer) and saturate
  assign r_full = acc_sum[39:16];
  always_comb begin
    priority if (r_full > 24'sd32767) begin
      r_sat = 16'sh7FFF;
    end else if (r_full < -24'sd32768) begin
      r_sat = 16'sh8000;
    end else begin
      r_sat = r_full[15:0];
    end
  end

  always_comb begin
    l_wr  = 1'b0;
    l_val = '0;
    if (st_r == CS_DIVI) begin
      if (n2_r == '0) begin
        l_wr = 1'b1;
      end else if (big) begin
        l_wr  = 1'b1;
        l_val = 18'h3FFFF;
      end
    end else if (st_r == CS_DIV && cnt_r == '0) begin
      l_wr  = 1'b1;
      l_val = q_fin;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      CS_IDLE: if (start) st_nxt = CS_MUL;
      CS_MUL:  st_nxt = CS_ACC;
      CS_ACC: begin
        if (!j_r) begin
          st_nxt = CS_MUL;
        end else begin
          unique case (ph_r)
            3'd1, 3'd3: st_nxt = CS_DIVI;
            3'd5:       st_nxt = CS_IDLE;
            default:    st_nxt = CS_MUL;
          endcase
        end
      end
      CS_DIVI: st_nxt = l_wr ? CS_MUL : CS_DIV;
      CS_DIV:  if (cnt_r == '0) st_nxt = CS_MUL;
      default: st_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= CS_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == CS_ACC) && j_r && (ph_r == 3'd5);
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      CS_IDLE: begin
        if (start) begin
          x_r   <= pos_x;
          y_r   <= pos_y;
          ph_r  <= 3'd0;
          j_r   <= 1'b0;
          acc_r <= '0;
        end
      end
      CS_MUL: prod_r <= mul;
      CS_ACC: begin
        if (!j_r) begin
          acc_r <= acc_sum;
          j_r   <= 1'b1;
        end else begin
          j_r  <= 1'b0;
          ph_r <= ph_r + 3'd1;
          unique case (ph_r)
            3'd0, 3'd2: begin
              dot_r <= acc_sum[34:0];
              acc_r <= '0;
            end
            3'd1, 3'd3: n2_r <= acc_sum[33:0];
            3'd4: begin
              sx_r  <= r_sat;
              acc_r <= init_y;
            end
            default: sy_r <= r_sat;
          endcase
        end
      end
      CS_DIVI: begin
        rem_r <= {2'b00, a_mag[33:2]};
        nb_r  <= {a_mag[1:0], 16'd0};
        q_r   <= '0;
        cnt_r <= 5'd17;
      end
      CS_DIV: begin
        rem_r <= ge ? rem_sub[33:0] : rem_sh[33:0];
        q_r   <= q_fin;
        nb_r  <= {nb_r[16:0], 1'b0};
        cnt_r <= cnt_r - 5'd1;
      end
      default: ;
    endcase
    if (l_wr) begin
      if (ph_r == 3'd2) l1_r <= l_val;
      else              l2_r <= l_val;
      acc_r <= (ph_r == 3'd4) ? init_x : 40'sd0;
    end
  end

  assign done  = done_r;
  assign scr_x = sx_r;
  assign scr_y = sy_r;

endmodule

// File: hdl/ttc_dp.sv
// datapath: configuration, touch table, scan compare, event and output registers
module ttc_dp #(
  parameter  int TABLE_DEPTH = 16,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ttc_pkg::ttc_cmd_t  cmd,
  input  logic [IW-1:0]      rd_addr,
  output ttc_pkg::ttc_sts_t  sts,
  input  logic               in_kind,
  input  logic        [31:0] in_now_ms,
  input  logic signed [15:0] in_finger_id,
  input  logic signed [15:0] in_touch_x,
  input  logic signed [15:0] in_touch_y,
  input  logic        [15:0] in_press_lvl,
  input  logic               cfg_we,
  input  logic        [2:0]  cfg_idx,
  input  logic        [31:0] cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic        [1:0]  out_event_type,
  output logic        [14:0] out_event_id,
  output logic signed [15:0] out_screen_x,
  output logic signed [15:0] out_screen_y,
  output logic signed [15:0] out_raw_x,
  output logic signed [15:0] out_raw_y,
  output logic        [15:0] out_pressure,
  output logic               out_last_of_run
);
  import ttc_pkg::*;

  logic [15:0] tmo_r;
  logic [31:0] scr0_r, scr1_r, scr2_r, sen0_r, sen1_r, sen2_r;

  logic        kind_r;
  logic [31:0] now_r;
  logic [15:0] id_r, x_r, y_r, pr_r;

  slot_t mem [TABLE_DEPTH];
  slot_t rd_q;
  logic [TABLE_DEPTH-1:0] vld_r, exp_r;

  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;
  scan_mode_t    cmp_mode_r;

  logic          hit_r, free_r, best_r;
  logic [IW-1:0] hit_idx_r, free_idx_r, best_idx_r;
  slot_t         best_q_r;
  logic [CW-1:0] left_r;

  ev_type_t    ev_type_r;
  logic [14:0] ev_id_r;
  logic [15:0] ev_x_r, ev_y_r, ev_pr_r;

  logic        out_vld_r;
  ev_type_t    o_type_r;
  logic [14:0] o_id_r;
  logic [15:0] o_sx_r, o_sy_r, o_x_r, o_y_r, o_pr_r;
  logic        o_last_r;

  logic               cal_done;
  logic signed [15:0] cal_x, cal_y;

  logic          cur_vld, expd, cur_exp;
  logic [31:0]   age;
  logic          hit_now, free_now, take_min;
  logic [IW-1:0] slot_sel;
  logic          wr_en, rm_en, out_free;

  assign cur_vld  = vld_r[cmp_idx_r];
  assign age      = now_r - rd_q.seen;
  assign expd     = cur_vld && (age > {16'd0, tmo_r});
  assign cur_exp  = (cmp_mode_r == MODE_EXP) ? expd : exp_r[cmp_idx_r];
  assign hit_now  = cmp_vld_r && (cmp_mode_r == MODE_FIND) && cur_vld && (rd_q.id == id_r[14:0]);
  assign free_now = cmp_vld_r && (cmp_mode_r == MODE_FIND) && !cur_vld && !free_r;
  assign take_min = cmp_vld_r && (cmp_mode_r != MODE_FIND) && cur_exp &&
                    (!best_r || (rd_q.id < best_q_r.id));
  assign slot_sel = hit_r ? hit_idx_r : free_idx_r;
  assign wr_en    = cmd.ev_load && !kind_r && (hit_r || free_r);
  assign rm_en    = cmd.ev_load && kind_r;
  assign out_free = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r      <= TIMEOUT_RST;
      scr0_r     <= SCR_ZERO_RST;
      scr1_r     <= SCR_ONE_RST;
      scr2_r     <= SCR_TWO_RST;
      sen0_r     <= SEN_ZERO_RST;
      sen1_r     <= SEN_ONE_RST;
      sen2_r     <= SEN_TWO_RST;
      vld_r      <= '0;
      exp_r      <= '0;
      cmp_vld_r  <= 1'b0;
      cmp_mode_r <= MODE_FIND;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      best_r     <= 1'b0;
      left_r     <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_TIMEOUT:  tmo_r  <= cfg_data[15:0];
          CFG_SCR_ZERO: scr0_r <= cfg_data;
          CFG_SCR_ONE:  scr1_r <= cfg_data;
          CFG_SCR_TWO:  scr2_r <= cfg_data;
          CFG_SEN_ZERO: sen0_r <= cfg_data;
          CFG_SEN_ONE:  sen1_r <= cfg_data;
          CFG_SEN_TWO:  sen2_r <= cfg_data;
          default: ;
        endcase
      end
      cmp_vld_r  <= cmd.rd_en;
      cmp_mode_r <= cmd.mode;
      if (cmd.scan_clr) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
        best_r <= 1'b0;
      end else begin
        if (hit_now)  hit_r  <= 1'b1;
        if (free_now) free_r <= 1'b1;
        if (take_min) best_r <= 1'b1;
      end
      priority if (cmd.load_in) begin
        left_r <= '0;
      end else if (cmp_vld_r && (cmp_mode_r == MODE_EXP) && expd) begin
        left_r <= left_r + CW'(1);
      end else if (rm_en) begin
        left_r <= left_r - CW'(1);
      end else begin
        left_r <= left_r;
      end
      if (cmp_vld_r && (cmp_mode_r == MODE_EXP)) exp_r[cmp_idx_r] <= expd;
      if (wr_en) vld_r[slot_sel] <= 1'b1;
      if (rm_en) begin
        vld_r[best_idx_r] <= 1'b0;
        exp_r[best_idx_r] <= 1'b0;
      end
      if (cmd.out_load)  out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= in_kind;
      now_r  <= in_now_ms;
      id_r   <= in_finger_id;
      x_r    <= in_touch_x;
      y_r    <= in_touch_y;
      pr_r   <= in_press_lvl;
    end
    cmp_idx_r <= rd_addr;
    if (hit_now)  hit_idx_r  <= cmp_idx_r;
    if (free_now) free_idx_r <= cmp_idx_r;
    if (take_min) begin
      best_idx_r <= cmp_idx_r;
      best_q_r   <= rd_q;
    end
    if (cmd.ev_load) begin
      if (kind_r) begin
        ev_type_r <= EV_REMOVE;
        ev_id_r   <= best_q_r.id;
        ev_x_r    <= best_q_r.x;
        ev_y_r    <= best_q_r.y;
        ev_pr_r   <= best_q_r.pr;
      end else begin
        ev_type_r <= hit_r ? EV_MOVE : (free_r ? EV_ADD : EV_DROP);
        ev_id_r   <= id_r[14:0];
        ev_x_r    <= x_r;
        ev_y_r    <= y_r;
        ev_pr_r   <= pr_r;
      end
    end
    if (cmd.out_load) begin
      o_type_r <= ev_type_r;
      o_id_r   <= ev_id_r;
      o_sx_r   <= cal_x;
      o_sy_r   <= cal_y;
      o_x_r    <= ev_x_r;
      o_y_r    <= ev_y_r;
      o_pr_r   <= ev_pr_r;
      o_last_r <= cmd.last;
    end
  end

  // touch table storage
  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_q <= mem[rd_addr];
    if (wr_en) mem[slot_sel] <= '{id: id_r[14:0], x: x_r, y: y_r, pr: pr_r, seen: now_r};
  end

  ttc_cal u_cal (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.cal_start),
    .pos_x    ($signed(ev_x_r)),
    .pos_y    ($signed(ev_y_r)),
    .scr_zero (scr0_r),
    .scr_one  (scr1_r),
    .scr_two  (scr2_r),
    .sen_zero (sen0_r),
    .sen_one  (sen1_r),
    .sen_two  (sen2_r),
    .done     (cal_done),
    .scr_x    (cal_x),
    .scr_y    (cal_y)
  );

  assign sts.kind      = kind_r;
  assign sts.id_neg    = id_r[15];
  assign sts.best      = best_r;
  assign sts.none_left = (left_r == '0);
  assign sts.cal_done  = cal_done;
  assign sts.out_free  = out_free;

  assign out_valid       = out_vld_r;
  assign out_event_type  = o_type_r;
  assign out_event_id    = o_id_r;
  assign out_screen_x    = o_sx_r;
  assign out_screen_y    = o_sy_r;
  assign out_raw_x       = o_x_r;
  assign out_raw_y       = o_y_r;
  assign out_pressure    = o_pr_r;
  assign out_last_of_run = o_last_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_vld_r || out_ready))
    else $error("result beat loaded over a pending one");

  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ev_load && !kind_r && hit_r) |-> vld_r[hit_idx_r])
    else $error("move event on an empty slot");

  a_left_dec: assert property (@(posedge clk) disable iff (!rst_n)
    rm_en |=> (left_r == CW'($past(left_r) - CW'(1))))
    else $error("expired count not decremented on removal");

  a_rm_valid: assert property (@(posedge clk) disable iff (!rst_n)
    rm_en |-> (vld_r[best_idx_r] && exp_r[best_idx_r]))
    else $error("removal of a slot that is not an expired touch");

endmodule

// File: hdl/ttc_ctrl.sv
// controller: sequences table scans, slot updates, calibration and result beats
module ttc_ctrl #(
  parameter  int TABLE_DEPTH = 16,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ttc_pkg::ttc_sts_t sts,
  output ttc_pkg::ttc_cmd_t cmd,
  output logic [IW-1:0]     rd_addr
);
  import ttc_pkg::*;

  ctrl_st_t      st_r, st_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          last;

  assign last    = !sts.kind || sts.none_left || (n_r == NW'(MAX_RESULTS - 1));
  assign rd_addr = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      idx_r <= '0;
      n_r   <= '0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      n_r   <= n_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    n_nxt    = n_r;
    in_ready = 1'b0;
    cmd      = '0;
    cmd.mode = MODE_FIND;
    unique case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          st_nxt      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.kind && sts.id_neg) begin
          st_nxt = ST_IDLE;
        end else begin
          cmd.scan_clr = 1'b1;
          idx_nxt      = '0;
          n_nxt        = '0;
          st_nxt       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (!sts.kind)         cmd.mode = MODE_FIND;
        else if (n_r == '0)    cmd.mode = MODE_EXP;
        else                   cmd.mode = MODE_MIN;
        if (idx_r == IW'(TABLE_DEPTH - 1)) begin
          st_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_DRAIN: st_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (sts.kind && !sts.best) begin
          st_nxt = ST_IDLE;
        end else begin
          cmd.ev_load = 1'b1;
          st_nxt      = ST_START;
        end
      end
      ST_START: begin
        cmd.cal_start = 1'b1;
        st_nxt        = ST_CALC;
      end
      ST_CALC: if (sts.cal_done) st_nxt = ST_OUT;
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.last     = last;
          if (last) begin
            st_nxt = ST_IDLE;
          end else begin
            n_nxt        = n_r + NW'(1);
            cmd.scan_clr = 1'b1;
            idx_nxt      = '0;
            st_nxt       = ST_SCAN;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/touch_tracker_with_calibration.sv
// touch tracker top level: controller, datapath with touch table and calibration unit
// one item at a time; a report's event beat becomes valid in the same cycle in which the input
// is ready again; each further remove of a sweep takes another table scan and calibration;
// each beat is paced by one table scan (one memory read a cycle) and the calibration unit
// (one shared multiplier, per basis vector an 18-step division after a setup step, skipped for a
// zero-length or saturating basis); a stalled output adds its wait
// synchronous active-low reset clears the table valid bits and loads register defaults
module touch_tracker_with_calibration #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ttc_in_if.sink      in_ch,
  ttc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data
);
  import ttc_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  ttc_cmd_t      cmd;
  ttc_sts_t      sts;
  logic [IW-1:0] rd_addr;

  ttc_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  ttc_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .rd_addr           (rd_addr),
    .sts               (sts),
    .in_kind           (in_ch.kind),
    .in_now_ms         (in_ch.now_ms),
    .in_finger_id      (in_ch.finger_id),
    .in_touch_x        (in_ch.touch_x),
    .in_touch_y        (in_ch.touch_y),
    .in_press_lvl      (in_ch.press_lvl),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_data          (cfg_data),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_event_type    (out_ch.event_type),
    .out_event_id      (out_ch.event_id),
    .out_screen_x      (out_ch.screen_x),
    .out_screen_y      (out_ch.screen_y),
    .out_raw_x         (out_ch.raw_x),
    .out_raw_y         (out_ch.raw_y),
    .out_pressure      (out_ch.pressure),
    .out_last_of_run   (out_ch.last_of_run)
  );

endmodule
